// ===== src/mnrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnrg_pkg
// Shared constants, codes and types of the MIDI note roll generator.
// ----------------------------------------------------------------------------
package mnrg_pkg;

  localparam int NOTES      = 32;
  localparam int PHASE_BITS = 20;
  localparam int NOTE_IDX_W = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam int CFG_W      = 20;
  localparam int CMP_W      = (PHASE_BITS > CFG_W) ? PHASE_BITS : CFG_W;

  localparam int NOTE_W  = 7;
  localparam int CHAN_W  = 4;
  localparam int VEL_W   = 7;
  localparam int MSG_W   = 24;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // results of one item beyond this count are dropped
  localparam int MAX_RESULTS = 64;
  localparam int EV_CNT_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [CFG_W-1:0] INTERVAL_RESET = CFG_W'(2756);
  localparam logic [CFG_W-1:0] GATE_RESET     = CFG_W'(1654);
  localparam logic [VEL_W-1:0] VEL_RESET      = VEL_W'(80);

  typedef enum logic [2:0] {
    CMD_NOTE_ON  = 3'd0,
    CMD_NOTE_OFF = 3'd1,
    CMD_TICK     = 3'd2,
    CMD_STROKE   = 3'd3,
    CMD_OTHER    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STROKE_SINGLE = 2'd0,
    STROKE_DOUBLE = 2'd1,
    STROKE_ROLL   = 2'd2
  } stroke_t;

  typedef enum logic [1:0] {
    KIND_ON   = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_PASS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_GATE     = 2'd1,
    CFG_ROLL_ALL = 2'd2
  } cfg_idx_t;

  // event sources
  typedef enum logic [2:0] {
    EV_IN_ON,
    EV_IN_OFF,
    EV_RAW,
    EV_NOTE_ON,
    EV_NOTE_OFF,
    EV_NOTE_OFF0
  } ev_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TRIG,
    ST_GATE,
    ST_WRAP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [NOTE_W-1:0]  note;
    logic [CHAN_W-1:0]  chan;
    logic [VEL_W-1:0]   vel;
    logic [MSG_W-1:0]   msg;
  } ev_t;

  typedef struct packed {
    logic    load_item;
    logic    note_on_wr;
    logic    note_off_wr;
    logic    stroke_wr;
    logic    idx_clr;
    logic    idx_inc;
    logic    next_load;
    logic    set_trig;
    logic    clear_note;
    logic    phase_wrap;
    logic    phase_step;
    logic    emit;
    ev_sel_t ev_sel;
    logic    flush;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic in_range;
    logic stroke_ok;
    logic playing;
    logic roll;
    logic trig;
    logic stop;
    logic gate_hit;
    logic wrap;
    logic emit_ok;
    logic flush_ok;
    logic last_note;
  } dp_status_t;

endpackage

// ===== src/mnrg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnrg_ctrl
// Sequencer: decodes each item and walks the note table on a frame tick.
// ----------------------------------------------------------------------------
module mnrg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  mnrg_pkg::dp_status_t   status,
  output mnrg_pkg::ctrl_cmd_t    cmd
);
  import mnrg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic adv;
    adv       = 1'b0;
    state_nxt = state_r;
    cmd       = '0;
    cmd.ev_sel = EV_RAW;
    in_tready = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end

      ST_DECODE: begin
        // the event holder is empty here, so an emit never waits
        unique case (status.cmd)
          CMD_NOTE_ON: begin
            if (status.in_range) begin
              cmd.note_on_wr = 1'b1;
            end else begin
              cmd.emit   = 1'b1;
              cmd.ev_sel = EV_IN_ON;
            end
            state_nxt = ST_FLUSH;
          end
          CMD_NOTE_OFF: begin
            if (status.in_range) begin
              cmd.note_off_wr = 1'b1;
            end else begin
              cmd.emit   = 1'b1;
              cmd.ev_sel = EV_IN_OFF;
            end
            state_nxt = ST_FLUSH;
          end
          CMD_TICK: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = ST_TRIG;
          end
          CMD_STROKE: begin
            cmd.stroke_wr = status.in_range && status.stroke_ok;
            state_nxt     = ST_FLUSH;
          end
          CMD_OTHER: begin
            cmd.emit   = 1'b1;
            cmd.ev_sel = EV_RAW;
            state_nxt  = ST_FLUSH;
          end
          default: begin
            state_nxt = ST_FLUSH;
          end
        endcase
      end

      ST_TRIG: begin
        cmd.next_load = 1'b1;
        if (!status.playing) begin
          adv = 1'b1;
        end else if (status.roll) begin
          if (!status.trig) begin
            if (status.emit_ok) begin
              cmd.emit     = 1'b1;
              cmd.ev_sel   = EV_NOTE_ON;
              cmd.set_trig = 1'b1;
              state_nxt    = ST_GATE;
            end
          end else begin
            state_nxt = ST_GATE;
          end
        end else if (!status.trig) begin
          if (status.emit_ok) begin
            cmd.emit     = 1'b1;
            cmd.ev_sel   = EV_NOTE_ON;
            cmd.set_trig = 1'b1;
            adv          = 1'b1;
          end
        end else if (status.stop) begin
          if (status.emit_ok) begin
            cmd.emit       = 1'b1;
            cmd.ev_sel     = EV_NOTE_OFF0;
            cmd.clear_note = 1'b1;
            adv            = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
      end

      ST_GATE: begin
        if (!status.gate_hit) begin
          state_nxt = ST_WRAP;
        end else if (status.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.ev_sel = EV_NOTE_OFF;
          state_nxt  = ST_WRAP;
        end
      end

      ST_WRAP: begin
        if (!status.wrap) begin
          cmd.phase_step = 1'b1;
          adv            = 1'b1;
        end else if (status.stop) begin
          cmd.clear_note = 1'b1;
          adv            = 1'b1;
        end else if (status.emit_ok) begin
          cmd.phase_wrap = 1'b1;
          cmd.emit       = 1'b1;
          cmd.ev_sel     = EV_NOTE_ON;
          adv            = 1'b1;
        end
      end

      ST_FLUSH: begin
        if (status.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (adv) begin
      if (status.last_note) begin
        state_nxt = ST_FLUSH;
      end else begin
        cmd.idx_inc = 1'b1;
        state_nxt   = ST_TRIG;
      end
    end
  end

endmodule

// ===== src/mnrg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnrg_dp
// Datapath: note table, config registers, item latch, event holder, output.
// ----------------------------------------------------------------------------
module mnrg_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [2:0]                            in_command,
  input  logic [mnrg_pkg::NOTE_W-1:0]           in_note,
  input  logic [mnrg_pkg::CHAN_W-1:0]           in_channel,
  input  logic [mnrg_pkg::VEL_W-1:0]            in_velocity,
  input  logic [1:0]                            in_stroke,
  input  logic [mnrg_pkg::MSG_W-1:0]            in_raw_message,
  input  logic                                  cfg_valid,
  input  logic [1:0]                            cfg_index,
  input  logic [mnrg_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  out_ready,
  input  mnrg_pkg::ctrl_cmd_t                   cmd,
  output mnrg_pkg::dp_status_t                  status,
  output logic                                  out_valid,
  output mnrg_pkg::ev_t                         out_ev,
  output logic                                  out_last
);
  import mnrg_pkg::*;

  // config
  logic [CFG_W-1:0] interval_r;
  logic [CFG_W-1:0] gate_r;
  logic             roll_all_r;

  // current item
  logic [2:0]        item_cmd_r;
  logic [NOTE_W-1:0] item_note_r;
  logic [CHAN_W-1:0] item_chan_r;
  logic [VEL_W-1:0]  item_vel_r;
  logic [1:0]        item_stroke_r;
  logic [MSG_W-1:0]  item_msg_r;

  // note table
  logic [NOTES-1:0]      playing_r;
  logic [NOTES-1:0]      stop_r;
  logic [NOTES-1:0]      trig_r;
  logic [PHASE_BITS-1:0] phase_r [NOTES];
  logic [VEL_W-1:0]      vel_r   [NOTES];
  logic [CHAN_W-1:0]     chan_r  [NOTES];
  stroke_t               mode_r  [NOTES];

  logic [NOTE_IDX_W-1:0] idx_r;
  logic [PHASE_BITS-1:0] next_r;

  ev_t  pend_r;
  logic pend_valid_r;
  ev_t  out_ev_r;
  logic out_valid_r;
  logic out_last_r;
  logic [EV_CNT_W-1:0] ev_cnt_r;

  logic [NOTE_IDX_W-1:0] item_idx;
  logic                  out_free;
  logic                  emit_en;
  logic                  move;
  cmd_t                  cmd_eff;
  ev_t                   ev;

  assign item_idx = item_note_r[NOTE_IDX_W-1:0];
  assign out_free = !out_valid_r || out_ready;
  // events past the per-item cap are dropped, the note state still advances
  assign emit_en  = cmd.emit && (ev_cnt_r < EV_CNT_W'(MAX_RESULTS));
  assign move     = (emit_en || cmd.flush) && pend_valid_r;

  // a zero-velocity note-on acts as a note-off
  always_comb begin
    cmd_eff = cmd_t'(item_cmd_r);
    if (cmd_t'(item_cmd_r) == CMD_NOTE_ON && item_vel_r == '0) begin
      cmd_eff = CMD_NOTE_OFF;
    end
  end

  always_comb begin
    status.cmd       = cmd_eff;
    status.in_range  = (item_note_r < NOTE_W'(NOTES));
    status.stroke_ok = (item_stroke_r != 2'd3);
    status.playing   = playing_r[idx_r];
    status.roll      = roll_all_r || (mode_r[idx_r] == STROKE_ROLL);
    status.trig      = trig_r[idx_r];
    status.stop      = stop_r[idx_r];
    status.gate_hit  = (CMP_W'(next_r) == CMP_W'(gate_r));
    status.wrap      = (CMP_W'(next_r) >= CMP_W'(interval_r));
    status.emit_ok   = !pend_valid_r || out_free;
    status.flush_ok  = !pend_valid_r || out_free;
    status.last_note = (idx_r == NOTE_IDX_W'(NOTES - 1));
  end

  always_comb begin
    ev = '0;
    case (cmd.ev_sel)
      EV_IN_ON, EV_IN_OFF: begin
        ev.kind = (cmd.ev_sel == EV_IN_ON) ? KIND_ON : KIND_OFF;
        ev.note = item_note_r;
        ev.chan = item_chan_r;
        ev.vel  = item_vel_r;
      end
      EV_RAW: begin
        ev.kind = KIND_PASS;
        ev.msg  = item_msg_r;
      end
      EV_NOTE_ON, EV_NOTE_OFF, EV_NOTE_OFF0: begin
        ev.kind = (cmd.ev_sel == EV_NOTE_ON) ? KIND_ON : KIND_OFF;
        ev.note = NOTE_W'(idx_r);
        ev.chan = chan_r[idx_r];
        ev.vel  = (cmd.ev_sel == EV_NOTE_OFF0) ? '0 : vel_r[idx_r];
      end
      default: begin
        ev = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
      gate_r     <= GATE_RESET;
      roll_all_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INTERVAL: interval_r <= cfg_data;
        CFG_GATE:     gate_r     <= cfg_data;
        CFG_ROLL_ALL: roll_all_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd_r    <= in_command;
      item_note_r   <= in_note;
      item_chan_r   <= in_channel;
      item_vel_r    <= in_velocity;
      item_stroke_r <= in_stroke;
      item_msg_r    <= in_raw_message;
    end
    if (cmd.next_load) begin
      next_r <= phase_r[idx_r] + PHASE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + NOTE_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_cnt_r <= '0;
    end else if (cmd.load_item) begin
      ev_cnt_r <= '0;
    end else if (emit_en) begin
      ev_cnt_r <= ev_cnt_r + EV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= '0;
      stop_r    <= '0;
      trig_r    <= '0;
      for (int i = 0; i < NOTES; i++) begin
        phase_r[i] <= '0;
        vel_r[i]   <= VEL_RESET;
        chan_r[i]  <= '0;
        mode_r[i]  <= STROKE_ROLL;
      end
    end else begin
      if (cmd.note_on_wr) begin
        vel_r[item_idx]     <= item_vel_r;
        chan_r[item_idx]    <= item_chan_r;
        playing_r[item_idx] <= 1'b1;
        stop_r[item_idx]    <= 1'b0;
        phase_r[item_idx]   <= '0;
      end
      if (cmd.note_off_wr) begin
        chan_r[item_idx] <= item_chan_r;
        stop_r[item_idx] <= 1'b1;
      end
      if (cmd.stroke_wr) begin
        mode_r[item_idx] <= stroke_t'(item_stroke_r);
      end
      if (cmd.set_trig) begin
        trig_r[idx_r] <= 1'b1;
      end
      if (cmd.clear_note) begin
        trig_r[idx_r]    <= 1'b0;
        playing_r[idx_r] <= 1'b0;
        stop_r[idx_r]    <= 1'b0;
      end
      if (cmd.phase_step) begin
        phase_r[idx_r] <= next_r;
      end
      if (cmd.phase_wrap) begin
        phase_r[idx_r] <= PHASE_BITS'(CMP_W'(next_r) - CMP_W'(interval_r));
      end
    end
  end

  // One event is held back so the final one of an item can carry last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit_en) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      pend_r <= ev;
    end
    if (move) begin
      out_ev_r   <= pend_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ev    = out_ev_r;
  assign out_last  = out_last_r;

endmodule

// ===== src/midi_note_roll_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_roll_generator
// Per-note repeat engine: single-stroke and roll notes driven by frame ticks.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Note-on, note-off, set-stroke and pass-through
// items pass through a decode and a flush state. A frame tick walks the 32-entry
// note table one entry at a time in a single sequencer; an idle or non-roll note
// takes only the trigger step and a playing roll note the trigger, gate and wrap
// steps, and the result side can hold off any step that emits or flushes. Results
// of one item leave in order with tlast on the final one; an item that makes no
// result makes no transfer. Configuration writes are accepted every cycle.
module midi_note_roll_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // note[6:0], channel[10:7], velocity[17:11], stroke[19:18],
  // raw_message[43:20], zero pad[47:44]
  input  logic [mnrg_pkg::IN_TDATA_W-1:0]      in_tdata,
  // command[2:0]
  input  logic [2:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_note[6:0], out_channel[10:7], out_velocity[17:11],
  // out_message[41:18], zero pad[47:42]
  output logic [mnrg_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // kind[1:0]
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [mnrg_pkg::CFG_W-1:0]           cfg_data
);
  import mnrg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  ev_t        out_ev;

  assign cfg_ready = 1'b1;

  mnrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mnrg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_tuser),
    .in_note        (in_tdata[6:0]),
    .in_channel     (in_tdata[10:7]),
    .in_velocity    (in_tdata[17:11]),
    .in_stroke      (in_tdata[19:18]),
    .in_raw_message (in_tdata[43:20]),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_tready),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_tvalid),
    .out_ev         (out_ev),
    .out_last       (out_tlast)
  );

  assign out_tdata = {6'd0, out_ev.msg, out_ev.vel, out_ev.chan, out_ev.note};
  assign out_tuser = out_ev.kind;

endmodule

// ===== src/mnrg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnrg_checker
// Port-level checks of the roll generator, bound to the top level.
// ----------------------------------------------------------------------------
module mnrg_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [mnrg_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic [1:0]                           out_tuser,
  input logic                                 out_tlast
);
  import mnrg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // one item at a time: the input closes right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input stayed open after a transfer");

  // stored velocities are never zero, so no note-on goes out silent
  a_on_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'(KIND_ON) |-> out_tdata[17:11] != 7'd0)
    else $error("note-on with zero velocity");

  a_pass_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'(KIND_PASS) |-> out_tdata[17:0] == 18'd0)
    else $error("pass-through event carries note fields");

  a_note_msg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'(KIND_PASS) |-> out_tdata[41:18] == 24'd0)
    else $error("note event carries a raw message");

endmodule

bind midi_note_roll_generator mnrg_checker u_mnrg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
